// File: hdl/dfdl_pkg.sv
package dfdl_pkg;

   // field widths
   localparam int SAMPLE_W    = 16;
   localparam int LP_W        = 24;
   localparam int GAIN_W      = 16;
   localparam int DELAY_LEN_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REFLECTION   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DAMPING      = 2'd2;

   // reset values of the registers
   localparam logic [DELAY_LEN_W-1:0] DELAY_LENGTH_RESET = 12'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [LP_W-1:0]     lowpass_type;
   typedef logic [GAIN_W-1:0]          gain_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic read;      // beat accepted: capture sample, read delayed entry
      logic mul1;      // lowpass difference times coefficient
      logic lp;        // round, add and saturate the lowpass state
      logic mul2;      // reflection times lowpass state
      logic commit;    // write the fed-back sample, advance pointer
      logic out_load;  // load the delayed sample into the output register
   } cmd_type;

endpackage

// File: hdl/dfdl_req_if.sv
interface dfdl_req_if;
   import dfdl_pkg::*;

   logic       valid;
   logic       ready;
   sample_type in_sample;

   modport source (output valid, output in_sample, input ready);
   modport sink (input valid, input in_sample, output ready);
endinterface

// File: hdl/dfdl_rsp_if.sv
interface dfdl_rsp_if;
   import dfdl_pkg::*;

   logic       valid;
   logic       ready;
   sample_type out_sample;

   modport source (output valid, output out_sample, input ready);
   modport sink (input valid, input out_sample, output ready);
endinterface

// File: hdl/dfdl_ctrl.sv
module dfdl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output dfdl_pkg::cmd_type cmd
);
   import dfdl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL1  = 3'd1;
   localparam logic [2:0] S_LP    = 3'd2;
   localparam logic [2:0] S_MUL2  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_SEND  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a new beat
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.read = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_LP;
         end
         S_LP: begin
            cmd.lp   = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.commit = 1'b1;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/dfdl_datapath.sv
module dfdl_datapath #(
   parameter int MAX_DELAY = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dfdl_pkg::cmd_type                   cmd,
   input  dfdl_pkg::sample_type                in_sample,
   output dfdl_pkg::sample_type                out_sample,
   input  logic                                csr_write_enable,
   input  logic [dfdl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dfdl_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import dfdl_pkg::*;

   localparam int AW = $clog2(MAX_DELAY);
   localparam int CW = $clog2(MAX_DELAY + 1);
   localparam int XW = (CW > DELAY_LEN_W) ? CW : DELAY_LEN_W;
   localparam int P1_W = 43;
   localparam int P2_W = 41;

   // configuration registers
   logic [DELAY_LEN_W-1:0] delay_length_ff;
   gain_type               reflection_ff;
   gain_type               damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff <= DELAY_LENGTH_RESET;
         reflection_ff   <= '0;
         damping_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_DELAY_LENGTH: delay_length_ff <= csr_write_data[DELAY_LEN_W-1:0];
            REG_REFLECTION:   reflection_ff   <= csr_write_data;
            REG_DAMPING:      damping_ff      <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // pointer and fill count
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] count_ff, count_in;

   // clamp the delay and form the read address
   logic [XW-1:0] len_raw, len_c;
   logic [AW-1:0] len_a;
   logic [AW:0]   rd_diff, rd_wrap;
   logic [AW-1:0] rd_addr;
   logic          rd_hit;

   always_comb begin
      len_raw = XW'(delay_length_ff);
      priority if (len_raw == '0) begin
         len_c = XW'(1);
      end else if (len_raw > XW'(MAX_DELAY - 1)) begin
         len_c = XW'(MAX_DELAY - 1);
      end else begin
         len_c = len_raw;
      end
      len_a   = len_c[AW-1:0];
      rd_diff = {1'b0, wp_ff} - {1'b0, len_a};
      rd_wrap = rd_diff + (AW+1)'(MAX_DELAY);
      rd_addr = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
      // entries past the fill count have not been written yet and read as zero
      rd_hit  = XW'(count_ff) >= len_c;
   end

   // delay store
   sample_type mem [0:MAX_DELAY-1];
   sample_type rd_data_ff;
   logic       rd_hit_ff;
   sample_type x_ff;
   sample_type wr_data;

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.commit) begin
         mem[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_hit_ff <= rd_hit;
         x_ff      <= in_sample;
      end
   end

   sample_type delayed;
   assign delayed = rd_hit_ff ? rd_data_ff : '0;

   // lowpass difference times (1 - damping)
   lowpass_type             lp_ff, lp_in;
   logic signed [24:0]      diff;
   logic signed [17:0]      coef;
   logic signed [P1_W-1:0]  prod1_ff, prod1_in;

   always_comb begin
      diff     = 25'(signed'({delayed, 8'd0})) - 25'(lp_ff);
      coef     = signed'(18'(17'(65536) - {1'b0, damping_ff}));
      prod1_in = diff * coef;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= prod1_in;
      end
   end

   // round half up, accumulate and saturate
   logic signed [P1_W-1:0] rnd1;
   logic signed [27:0]     lp_sum;

   always_comb begin
      rnd1   = (prod1_ff + P1_W'(32768)) >>> 16;
      lp_sum = 28'(lp_ff) + rnd1[27:0];
      priority if (lp_sum > 28'sd8388607) begin
         lp_in = 24'sh7FFFFF;
      end else if (lp_sum < -28'sd8388608) begin
         lp_in = 24'sh800000;
      end else begin
         lp_in = lp_sum[LP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= '0;
      end else if (cmd.lp) begin
         lp_ff <= lp_in;
      end
   end

   // reflection times lowpass state
   logic signed [P2_W-1:0] prod2_ff, prod2_in;
   logic signed [16:0]     refl_s;

   always_comb begin
      refl_s   = signed'({1'b0, reflection_ff});
      prod2_in = refl_s * lp_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         prod2_ff <= prod2_in;
      end
   end

   // fed-back sample, saturated to 16 bits
   logic signed [P2_W-1:0] rnd2;
   logic signed [17:0]     w_full;

   always_comb begin
      rnd2   = (prod2_ff + P2_W'(8388608)) >>> 24;
      w_full = 18'(x_ff) - 18'(signed'(rnd2[16:0]));
      priority if (w_full > 18'sd32767) begin
         wr_data = 16'sh7FFF;
      end else if (w_full < -18'sd32768) begin
         wr_data = 16'sh8000;
      end else begin
         wr_data = w_full[SAMPLE_W-1:0];
      end
   end

   // pointer advance and fill count
   always_comb begin
      wp_in    = wp_ff;
      count_in = count_ff;
      if (cmd.commit) begin
         wp_in = (wp_ff == AW'(MAX_DELAY - 1)) ? '0 : wp_ff + AW'(1);
         if (count_ff != CW'(MAX_DELAY)) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         count_ff <= count_in;
      end
   end

   // output register
   sample_type out_sample_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sample_ff <= delayed;
      end
   end

   assign out_sample = out_sample_ff;

endmodule

// File: hdl/damped_feedback_delay_line.sv
// Lowpass feedback comb: each beat on the request channel carries one Q1.15 sample and gives
// exactly one response beat, the sample stored delay_length beats earlier (delay clamped to
// 1..MAX_DELAY-1). The stored value is the input minus reflection times a one-pole lowpass of
// the delayed signal, saturated to 16 bits. An item runs these steps before the next request
// can be accepted: the read of the delay store on acceptance, then the lowpass multiply, the
// lowpass accumulate, the reflection multiply and the store write, run one after another on a
// single datapath because each step needs the previous one. A response waiting in the output
// register does not hold up the next request; only when it is still untaken at the end of the
// following item does that item wait. The delay store is cleared logically by a fill count, so
// there is no clearing pass after reset. The user must write registers through the csr port
// only while no item is in flight; the block itself does not enforce it.
module damped_feedback_delay_line #(
   parameter int MAX_DELAY = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   dfdl_req_if.sink                          req_if,
   dfdl_rsp_if.source                        rsp_if,
   input  logic                              csr_write_enable,
   input  logic [dfdl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dfdl_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dfdl_pkg::*;

   cmd_type cmd;

   // sequencer
   dfdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   // delay store and arithmetic
   dfdl_datapath #(
      .MAX_DELAY (MAX_DELAY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .in_sample        (req_if.in_sample),
      .out_sample       (rsp_if.out_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

`ifndef SYNTH
   // one item at a time: no request beat directly after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while an item is in flight");

   // a store write ends the item accepted in S_IDLE, after S_MUL1, S_LP and S_MUL2
   a_commit_timing: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(req_if.valid && req_if.ready, 4))
      else $error("store write without matching accepted request");

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response register loaded while holding an untaken beat");
`endif

endmodule

// File: test/damped_feedback_delay_line_tb.sv
module damped_feedback_delay_line_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfdl_pkg::*;

   localparam int STORE_DEPTH    = 4096;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 7;

   // index with no register behind it, writes to it must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   // predicts the pipe output and holds the delayed samples still owed by the block
   class comb_predictor;
      shortint    delay_line [STORE_DEPTH];
      int         head;
      int         lowpass;
      int         delay_setting;
      int         reflection_gain;
      int         damping_gain;
      sample_type outputs_due [$];
      int         checked;
      int         failures;

      function void clear();
         foreach (delay_line[i]) delay_line[i] = 0;
         head            = 0;
         lowpass         = 0;
         delay_setting   = int'(DELAY_LENGTH_RESET);
         reflection_gain = 0;
         damping_gain    = 0;
         outputs_due.delete();
         checked         = 0;
         failures        = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_DELAY_LENGTH: delay_setting   = int'(data[DELAY_LEN_W-1:0]);
            REG_REFLECTION:   reflection_gain = int'(data);
            REG_DAMPING:      damping_gain    = int'(data);
            default: ;
         endcase
      endfunction

      // one input beat: read the tap, move the lowpass, write back the damped feedback
      function void take_sample(sample_type x);
         int     span;
         int     tap;
         longint delayed;
         longint coef;
         longint diff;
         longint lp_next;
         longint fb;
         longint stored;
         span = delay_setting;
         if (span < 1) span = 1;
         if (span > STORE_DEPTH - 1) span = STORE_DEPTH - 1;
         tap     = (head + STORE_DEPTH - span) % STORE_DEPTH;
         delayed = delay_line[tap];

         // one-pole lowpass in Q1.23, rounding half up
         coef    = 64'sd65536 - longint'(damping_gain);
         diff    = delayed * 256 - longint'(lowpass);
         lp_next = longint'(lowpass) + ((diff * coef + 64'sd32768) >>> 16);
         lowpass = int'(clamp(lp_next, -64'sd8388608, 64'sd8388607));

         // reflection of the lowpass state subtracted from the excitation
         fb     = (longint'(reflection_gain) * longint'(lowpass) + 64'sd8388608) >>> 24;
         stored = clamp(longint'(x) - fb, -64'sd32768, 64'sd32767);
         delay_line[head] = shortint'(stored);
         head = (head + 1) % STORE_DEPTH;
         outputs_due.push_back(sample_type'(delayed));
      endfunction

      function void match_output(sample_type got);
         sample_type want;
         checked++;
         if (outputs_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: output beat %0d with nothing owed", $realtime, got);
            return;
         end
         want = outputs_due.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: out_sample expected %0d got %0d", $realtime, want, got);
         end
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   dfdl_req_if req_bus ();
   dfdl_rsp_if rsp_bus ();

   comb_predictor prediction;

   bit send_steady;
   bit recv_steady;
   int stall_left = 0;
   int idle_cycles = 0;
   int samples_sent = 0;
   int settings_applied = 0;

   damped_feedback_delay_line dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return sample_type'(int'($urandom_range(0, 255)) - 128);
         3, 4:    return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (reset || recv_steady) begin
         rsp_bus.ready <= !reset;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= pause_length();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // check each output beat against the oldest owed sample
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         prediction.match_output(rsp_bus.out_sample);
   end

   // end the run if no beat moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d samples still owed",
                  WATCHDOG_LIMIT, prediction.pending());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_sample(input sample_type s);
      int gap;
      gap = send_steady ? 0 : pause_length();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.in_sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      prediction.take_sample(s);
      samples_sent++;
      @(negedge clock);
   endtask

   // wait for every owed sample, then let the last store write finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (prediction.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      prediction.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic apply_setting(input int delay, input int refl, input int damp);
      // spare upper bits of the delay write are junk and must be dropped
      write_register(REG_DELAY_LENGTH, {4'($urandom), 12'(delay)});
      write_register(REG_REFLECTION, 16'(refl));
      write_register(REG_DAMPING, 16'(damp));
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   initial begin
      sample_type at_reset_values [12];
      sample_type hard_feedback [12];
      int         phase_items [RANDOM_PHASES];

      at_reset_values = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sh5555,
                          16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000};
      hard_feedback   = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      phase_items     = '{150, 120, 160, 200, 150, 150, 150};

      prediction = new;
      prediction.clear();

      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = REG_DELAY_LENGTH;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.in_sample = '0;
      rsp_bus.ready     = 1'b0;
      send_steady       = 1'b0;
      recv_steady       = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // extremes at the reset settings
      foreach (at_reset_values[i]) send_sample(at_reset_values[i]);

      // dead index, zero delay and full reflection: stored samples saturate
      settle();
      write_register(REG_UNUSED, 16'hFFFF);
      apply_setting(0, 16'hFFFF, 0);
      foreach (hard_feedback[i]) send_sample(hard_feedback[i]);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: apply_setting($urandom_range(1, 16), 62259, 64880);
            1: apply_setting(4095, 0, 16'hFFFF);
            2: apply_setting($urandom_range(1, 16), 16'hFFFF, 16'hFFFF);
            3: apply_setting($urandom_range(1, 400), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
            4: apply_setting(7, 32768, 0);
            5: apply_setting($urandom_range(1, 64), 62259, 0);
            default: apply_setting($urandom_range(0, 4095), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
         endcase
         for (int i = 0; i < phase_items[p]; i++) begin
            // re-roll the pacing now and then so full-rate stretches turn up
            if (i % 40 == 0) begin
               send_steady = ($urandom_range(0, 3) == 0);
               recv_steady = ($urandom_range(0, 3) == 0);
            end
            send_sample(pick_sample());
         end
      end

      // drain and let the pipe go quiet
      send_steady = 1'b0;
      recv_steady = 1'b0;
      req_bus.valid <= 1'b0;
      while (prediction.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("pushed %0d samples through %0d register settings, checked %0d output beats",
               samples_sent, settings_applied, prediction.checked);
      $display("delays from one tap to the full store, gains and damping at both ends");
      if (prediction.failures == 0 && prediction.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures, %0d samples still owed", prediction.failures,
                  prediction.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
